>>> design/gsp_pkg.sv
`timescale 1ns / 1ps

package gsp_pkg;

  // distance field width and the marker for a cell not yet reached
  localparam int DIST_W = 13;
  localparam logic [DIST_W-1:0] UNREACHED = {DIST_W{1'b1}};

  // configuration register width and indexes
  localparam int CFG_W = 7;
  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  // eight neighbor steps, row and column deltas
  localparam logic signed [1:0] STEP_DR [8] = '{2'sd0, 2'sd0, -2'sd1, -2'sd1,
                                                -2'sd1, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] STEP_DC [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                                -2'sd1, 2'sd0, -2'sd1, 2'sd1};

  // search sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_START,
    ST_START_CHK,
    ST_POP,
    ST_NBR,
    ST_DRAIN,
    ST_GOAL,
    ST_GOAL_CHK,
    ST_DONE
  } gsp_state_t;

  // one search result, engine to output stage
  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] len;
  } gsp_res_t;

endpackage

>>> design/gsp_nbr.sv
`timescale 1ns / 1ps

// Neighbor generator: bounds check and cell index of step k from the current cell.
module gsp_nbr #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int CAP = MAX_ROWS * MAX_COLS,
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1,
  localparam int RCW = $clog2(MAX_ROWS + 1),
  localparam int CCW = $clog2(MAX_COLS + 1)
) (
  input  logic [RW-1:0]  cur_row,
  input  logic [CLW-1:0] cur_col,
  input  logic [IW-1:0]  cur_idx,
  input  logic [2:0]     step,
  input  logic [RCW-1:0] rows,
  input  logic [CCW-1:0] cols,
  output logic           nb_valid,
  output logic [RW-1:0]  nb_row,
  output logic [CLW-1:0] nb_col,
  output logic [IW-1:0]  nb_idx
);

  logic signed [1:0]     dr;
  logic signed [1:0]     dc;
  logic signed [RW+1:0]  nr;
  logic signed [CLW+1:0] nc;
  logic [IW-1:0]         roff;

  assign dr = gsp_pkg::STEP_DR[step];
  assign dc = gsp_pkg::STEP_DC[step];

  // neighbor coordinates and bounds
  assign nr = $signed({2'b00, cur_row}) + (RW+2)'(dr);
  assign nc = $signed({2'b00, cur_col}) + (CLW+2)'(dc);

  assign nb_valid = (nr >= 0) && (nr < $signed((RW+2)'(rows))) &&
                    (nc >= 0) && (nc < $signed((CLW+2)'(cols)));
  assign nb_row = nr[RW-1:0];
  assign nb_col = nc[CLW-1:0];

  // index offset: one row up or down is -/+ cols, modulo the index width
  always_comb begin
    if (dr < 0) begin
      roff = IW'(0) - IW'(cols);
    end else if (dr > 0) begin
      roff = IW'(cols);
    end else begin
      roff = '0;
    end
  end

  assign nb_idx = cur_idx + roff + IW'(dc);

endmodule

>>> design/gsp_engine.sv
`timescale 1ns / 1ps

// Grid loader and breadth-first search sequencer with its three memories.
module gsp_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int CAP = MAX_ROWS * MAX_COLS,
  localparam int CW  = $clog2(CAP + 1),
  localparam int RCW = $clog2(MAX_ROWS + 1),
  localparam int CCW = $clog2(MAX_COLS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  logic               in_blocked,
  input  logic               in_last,
  output logic               load_ready,
  input  logic [RCW-1:0]     rows_cl,
  input  logic [CCW-1:0]     cols_cl,
  input  logic [CW-1:0]      cells,
  output logic               res_valid,
  input  logic               res_ready,
  output gsp_pkg::gsp_res_t  res
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int DW  = gsp_pkg::DIST_W;
  localparam int QW  = DW + RW + CLW + IW;

  // sequencer and job state
  gsp_pkg::gsp_state_t state_r, state_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [RCW-1:0]    job_rows_r, job_rows_nxt;
  logic [CCW-1:0]    job_cols_r, job_cols_nxt;
  logic [IW-1:0]     goal_r, goal_nxt;
  logic [CW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     tail_r, tail_nxt;
  logic [2:0]        k_r, k_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [RW-1:0]     chk_row_r, chk_row_nxt;
  logic [CLW-1:0]    chk_col_r, chk_col_nxt;
  gsp_pkg::gsp_res_t res_r, res_nxt;

  // memories and registered read data
  logic          blk_mem [CAP];
  logic [DW-1:0] dist_mem [CAP];
  logic [QW-1:0] q_mem [CAP];
  logic          blk_q;
  logic [DW-1:0] dist_q;
  logic [QW-1:0] q_rd;

  logic          blk_we, blk_wd, blk_re;
  logic [IW-1:0] blk_wa, blk_ra;
  logic          dist_we, dist_re;
  logic [IW-1:0] dist_wa, dist_ra;
  logic [DW-1:0] dist_wd;
  logic          q_we, q_re;
  logic [IW-1:0] q_wa, q_ra;
  logic [QW-1:0] q_wd;

  // current cell, as popped from the queue
  logic [DW-1:0]  cur_d;
  logic [RW-1:0]  cur_row;
  logic [CLW-1:0] cur_col;
  logic [IW-1:0]  cur_idx;
  logic [DW-1:0]  nd;
  logic           nb_valid;
  logic [RW-1:0]  nb_row;
  logic [CLW-1:0] nb_col;
  logic [IW-1:0]  nb_idx;
  logic [CW-1:0]  cells_m1;
  logic           chk_take;

  assign cur_d   = q_rd[QW-1 -: DW];
  assign cur_row = q_rd[RW+CLW+IW-1 -: RW];
  assign cur_col = q_rd[CLW+IW-1 -: CLW];
  assign cur_idx = q_rd[IW-1:0];
  assign nd      = cur_d + DW'(1);
  assign cells_m1 = cells - CW'(1);

  gsp_nbr #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_nbr (
    .cur_row (cur_row),
    .cur_col (cur_col),
    .cur_idx (cur_idx),
    .step    (k_r),
    .rows    (job_rows_r),
    .cols    (job_cols_r),
    .nb_valid(nb_valid),
    .nb_row  (nb_row),
    .nb_col  (nb_col),
    .nb_idx  (nb_idx)
  );

  // neighbor from last cycle is open and not yet reached
  assign chk_take = chk_v_r && !blk_q && (dist_q == gsp_pkg::UNREACHED);

  // next state and memory controls
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    clr_nxt      = clr_r;
    job_rows_nxt = job_rows_r;
    job_cols_nxt = job_cols_r;
    goal_nxt     = goal_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    k_nxt        = k_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    chk_row_nxt  = chk_row_r;
    chk_col_nxt  = chk_col_r;
    res_nxt      = res_r;
    load_ready   = 1'b0;
    res_valid    = 1'b0;
    blk_we  = 1'b0;
    blk_wa  = pos_r[IW-1:0];
    blk_wd  = in_blocked;
    blk_re  = 1'b0;
    blk_ra  = '0;
    dist_we = 1'b0;
    dist_wa = '0;
    dist_wd = gsp_pkg::UNREACHED;
    dist_re = 1'b0;
    dist_ra = '0;
    q_we    = 1'b0;
    q_wa    = '0;
    q_wd    = '0;
    q_re    = 1'b0;
    q_ra    = head_r[IW-1:0];

    unique case (state_r)
      gsp_pkg::ST_LOAD: begin
        load_ready = 1'b1;
        if (in_take) begin
          blk_we = (pos_r < cells);
          if (pos_r != CW'(CAP)) begin
            pos_nxt = pos_r + CW'(1);
          end
          if (in_last) begin
            pos_nxt      = '0;
            job_rows_nxt = rows_cl;
            job_cols_nxt = cols_cl;
            goal_nxt     = cells_m1[IW-1:0];
            clr_nxt      = '0;
            state_nxt    = gsp_pkg::ST_CLEAR;
          end
        end
      end
      // set every distance of the grid to unreached
      gsp_pkg::ST_CLEAR: begin
        dist_we = 1'b1;
        dist_wa = clr_r;
        if (clr_r == goal_r) begin
          state_nxt = gsp_pkg::ST_START;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      gsp_pkg::ST_START: begin
        blk_re    = 1'b1;
        head_nxt  = '0;
        tail_nxt  = '0;
        state_nxt = gsp_pkg::ST_START_CHK;
      end
      // start blocked: no path; else seed the queue with the start cell
      gsp_pkg::ST_START_CHK: begin
        if (blk_q) begin
          res_nxt   = '0;
          state_nxt = gsp_pkg::ST_DONE;
        end else begin
          dist_we   = 1'b1;
          dist_wd   = '0;
          q_we      = 1'b1;
          tail_nxt  = CW'(1);
          state_nxt = gsp_pkg::ST_POP;
        end
      end
      gsp_pkg::ST_POP: begin
        if (head_r == tail_r) begin
          state_nxt = gsp_pkg::ST_GOAL;
        end else begin
          q_re      = 1'b1;
          head_nxt  = head_r + CW'(1);
          k_nxt     = '0;
          state_nxt = gsp_pkg::ST_NBR;
        end
      end
      // look up one neighbor a cycle; its check runs in the following cycle
      gsp_pkg::ST_NBR: begin
        blk_re      = 1'b1;
        dist_re     = 1'b1;
        blk_ra      = nb_valid ? nb_idx : '0;
        dist_ra     = nb_valid ? nb_idx : '0;
        chk_v_nxt   = nb_valid;
        chk_idx_nxt = nb_idx;
        chk_row_nxt = nb_row;
        chk_col_nxt = nb_col;
        k_nxt       = k_r + 3'd1;
        if (k_r == 3'd7) begin
          state_nxt = gsp_pkg::ST_DRAIN;
        end
      end
      gsp_pkg::ST_DRAIN: begin
        state_nxt = gsp_pkg::ST_POP;
      end
      gsp_pkg::ST_GOAL: begin
        dist_re   = 1'b1;
        dist_ra   = goal_r;
        state_nxt = gsp_pkg::ST_GOAL_CHK;
      end
      gsp_pkg::ST_GOAL_CHK: begin
        res_nxt.found = (dist_q != gsp_pkg::UNREACHED);
        res_nxt.len   = (dist_q != gsp_pkg::UNREACHED) ? dist_q + DW'(1) : '0;
        state_nxt     = gsp_pkg::ST_DONE;
      end
      gsp_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = gsp_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = gsp_pkg::ST_LOAD;
      end
    endcase

    // neighbor check: mark reached and enqueue
    if (chk_take) begin
      dist_we  = 1'b1;
      dist_wa  = chk_idx_r;
      dist_wd  = nd;
      q_we     = 1'b1;
      q_wa     = tail_r[IW-1:0];
      q_wd     = {nd, chk_row_r, chk_col_r, chk_idx_r};
      tail_nxt = tail_r + CW'(1);
    end
  end

  assign res = res_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsp_pkg::ST_LOAD;
      pos_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clr_r      <= clr_nxt;
    job_rows_r <= job_rows_nxt;
    job_cols_r <= job_cols_nxt;
    goal_r     <= goal_nxt;
    k_r        <= k_nxt;
    chk_idx_r  <= chk_idx_nxt;
    chk_row_r  <= chk_row_nxt;
    chk_col_r  <= chk_col_nxt;
    res_r      <= res_nxt;
  end

  // blocked map
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    if (blk_re) begin
      blk_q <= blk_mem[blk_ra];
    end
  end

  // distance store
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (dist_re) begin
      dist_q <= dist_mem[dist_ra];
    end
  end

  // search queue: {distance, row, col, index}
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd <= q_mem[q_ra];
    end
  end

endmodule

>>> design/grid_shortest_path_8way.sv
`timescale 1ns / 1ps

// Channel | Direction | Signals                             | Contents
// in_     | request   | in_tvalid/in_tready/in_tdata/tlast  | one grid cell, row-major
// out_    | result    | out_tvalid/out_tready/tdata/tuser   | path found and length
// cfg_    | write     | cfg_wr_en/cfg_index/cfg_wdata       | grid rows, grid cols
//
// Loading takes one cell per cycle while in_tready is high. After the last cell the
// distance store is cleared; then a start-cell check, and for each reached cell a queue
// pop, eight neighbor lookups through the shared neighbor unit and one drain, and last
// a goal lookup. Reset is synchronous, active low; memories are not reset. in_tready
// is low during a search, while a result waits for the output register, and for one
// cycle after a configuration write.
module grid_shortest_path_8way #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: [0] cell_blocked, [7:1] zero
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  input  logic                       in_tlast,
  // out_tdata: [12:0] path_length, [15:13] zero
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,
  // out_tuser: [0] path_found
  output logic                       out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [0:0]                 cfg_index,
  input  logic [gsp_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int CW  = $clog2(CAP + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int DW  = gsp_pkg::DIST_W;

  logic [gsp_pkg::CFG_W-1:0] rows_r, cols_r;
  logic                      cfg_pend_r;
  logic [RCW-1:0]            rows_cl;
  logic [CCW-1:0]            cols_cl;
  logic [RCW+CCW-1:0]        prod;
  logic [CW-1:0]             cells_r;
  logic                      load_ready;
  logic                      in_take;
  logic                      res_valid, res_ready;
  gsp_pkg::gsp_res_t         res;
  logic                      out_tvalid_r;
  logic                      out_found_r;
  logic [DW-1:0]             out_len_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= 7'd64;
      cols_r     <= 7'd64;
      cfg_pend_r <= 1'b1;
    end else begin
      cfg_pend_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          gsp_pkg::REG_ROWS: rows_r <= cfg_wdata;
          gsp_pkg::REG_COLS: cols_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // clamp dimensions: zero counts as one, large values saturate
  always_comb begin
    if (rows_r == '0) begin
      rows_cl = RCW'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      rows_cl = RCW'(MAX_ROWS);
    end else begin
      rows_cl = RCW'(rows_r);
    end
    if (cols_r == '0) begin
      cols_cl = CCW'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_cl = CCW'(MAX_COLS);
    end else begin
      cols_cl = CCW'(cols_r);
    end
  end

  // cell count, registered from the clamped dimensions; input is held off while it settles after a write
  assign prod = (RCW+CCW)'(rows_cl) * (RCW+CCW)'(cols_cl);
  always_ff @(posedge clk) begin
    cells_r <= prod[CW-1:0];
  end

  assign in_tready = load_ready && !cfg_pend_r;
  assign in_take   = in_tvalid && in_tready;

  gsp_engine #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_blocked(in_tdata[0]),
    .in_last   (in_tlast),
    .load_ready(load_ready),
    .rows_cl   (rows_cl),
    .cols_cl   (cols_cl),
    .cells     (cells_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_found_r <= res.found;
      out_len_r   <= res.len;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_len_r};
  assign out_tuser  = out_found_r;

endmodule
